>>> rtl/core/wcre_pkg.sv
// ----------------------------------------------------------------------------
// wcre_pkg
// Types and constants for the word-clock rate estimator.
// ----------------------------------------------------------------------------
package wcre_pkg;

  localparam int unsigned COUNT_W = 18;
  localparam int unsigned RATE_W  = 31;
  localparam int unsigned DIV_W   = COUNT_W + 1;
  localparam int unsigned PROD_W  = 38;
  localparam int unsigned STD_W   = 26;
  localparam int unsigned NUM_STD = 13;

  localparam logic [RATE_W-1:0] NUMERATOR = 31'd1280000000;

  typedef struct packed {
    logic               scan_ready;
    logic [COUNT_W-1:0] period_count;
  } scan_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_hz;
    logic              snapped;
    logic              rate_changed;
  } rate_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SNAP,
    ST_DONE
  } state_t;

  // standard rates, search order
  function automatic logic [DIV_W-1:0] std_rate(input logic [3:0] idx);
    logic [DIV_W-1:0] r;
    case (idx)
      4'd0:    r = 19'd22050;
      4'd1:    r = 19'd32000;
      4'd2:    r = 19'd44100;
      4'd3:    r = 19'd48000;
      4'd4:    r = 19'd64000;
      4'd5:    r = 19'd88200;
      4'd6:    r = 19'd96000;
      4'd7:    r = 19'd128000;
      4'd8:    r = 19'd176400;
      4'd9:    r = 19'd192000;
      4'd10:   r = 19'd256000;
      4'd11:   r = 19'd352800;
      4'd12:   r = 19'd384000;
      default: r = '0;
    endcase
    return r;
  endfunction

  // standard rate times 100
  function automatic logic [STD_W-1:0] std_rate_x100(input logic [3:0] idx);
    logic [STD_W-1:0] r;
    case (idx)
      4'd0:    r = 26'd2205000;
      4'd1:    r = 26'd3200000;
      4'd2:    r = 26'd4410000;
      4'd3:    r = 26'd4800000;
      4'd4:    r = 26'd6400000;
      4'd5:    r = 26'd8820000;
      4'd6:    r = 26'd9600000;
      4'd7:    r = 26'd12800000;
      4'd8:    r = 26'd17640000;
      4'd9:    r = 26'd19200000;
      4'd10:   r = 26'd25600000;
      4'd11:   r = 26'd35280000;
      4'd12:   r = 26'd38400000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/wordclock_rate_estimator_core.sv
// ----------------------------------------------------------------------------
// wordclock_rate_estimator_core
// Converts a word-clock period count to a rate in Hz, snaps it to a
// standard audio rate within 1 percent and flags rate changes.
//
// Usage:
//   scan channel (scan_valid / scan_stall / scan_item) takes one scan
//   result. scan_stall is high while an item is in work.
//   rate channel (rate_valid / rate_stall / rate_item) gives one result
//   per item from an output register.
// Steps: a ready item passes the restoring divider (one quotient bit
//   per cycle), a state for the 99/101 products, a table search (one
//   compare per cycle) and a state that loads the output. A not-ready
//   item goes straight to the load state.
// Items: one item at a time; the next scan item is taken only
//   after the last one has been loaded into the output register.
// Stall: a result waiting on rate_stall holds the output register; a
//   finished item then waits in the load state and scan_stall stays high.
// Reset: clears the sequencer, the output valid and the stored last rate.
// ----------------------------------------------------------------------------
module wordclock_rate_estimator_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           scan_valid,
  output logic           scan_stall,
  input  wcre_pkg::scan_t scan_item,
  output logic           rate_valid,
  input  logic           rate_stall,
  output wcre_pkg::rate_t rate_item
);

  import wcre_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [DIV_W-1:0]    divisor;
  logic [DIV_W-1:0]    rem;
  logic [RATE_W-1:0]   quot;
  logic [4:0]          bit_idx;
  logic [PROD_W-1:0]   lo;
  logic [PROD_W-1:0]   hi;
  logic [3:0]          std_idx;
  logic [RATE_W-1:0]   rate;
  logic                snap;
  logic [RATE_W-1:0]   last_rate;

  logic                accept;
  logic                out_load;
  logic [DIV_W:0]      shifted;
  logic [DIV_W:0]      diff;
  logic                take;
  logic [PROD_W-1:0]   raw_ext;
  logic [PROD_W-1:0]   s100;
  logic                hit;
  logic                last_std;

  // datapath
  assign shifted  = {rem, NUMERATOR[bit_idx]};
  assign diff     = shifted - {1'b0, divisor};
  assign take     = shifted >= {1'b0, divisor};
  assign raw_ext  = {{(PROD_W-RATE_W){1'b0}}, quot};
  assign s100     = {{(PROD_W-STD_W){1'b0}}, std_rate_x100(std_idx)};
  assign hit      = (s100 >= lo) && (s100 <= hi);
  assign last_std = std_idx == 4'(NUM_STD - 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (scan_valid) begin
          state_next = scan_item.scan_ready ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (bit_idx == '0) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_SNAP;
      ST_SNAP: begin
        if (hit || last_std) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rate_valid || !rate_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    scan_stall = state != ST_IDLE;
    accept     = (state == ST_IDLE) && scan_valid;
    out_load   = (state == ST_DONE) && (!rate_valid || !rate_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          divisor <= {1'b0, scan_item.period_count} + DIV_W'(1);
          rem     <= '0;
          quot    <= '0;
          bit_idx <= 5'(RATE_W - 1);
          std_idx <= '0;
          rate    <= '0;
          snap    <= 1'b0;
        end
      end
      ST_DIV: begin
        rem     <= take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quot    <= {quot[RATE_W-2:0], take};
        bit_idx <= bit_idx - 5'd1;
      end
      ST_MUL: begin
        lo   <= (raw_ext << 6) + (raw_ext << 5) + (raw_ext << 1) + raw_ext;
        hi   <= (raw_ext << 6) + (raw_ext << 5) + (raw_ext << 2) + raw_ext;
        rate <= quot;
      end
      ST_SNAP: begin
        if (hit) begin
          rate <= {{(RATE_W-DIV_W){1'b0}}, std_rate(std_idx)};
          snap <= 1'b1;
        end
        std_idx <= std_idx + 4'd1;
      end
      default: begin
      end
    endcase
  end

  // output register and stored rate
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_valid <= 1'b0;
      last_rate  <= '0;
    end else begin
      if (out_load) begin
        rate_valid <= 1'b1;
        last_rate  <= rate;
      end else if (!rate_stall) begin
        rate_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rate_item.rate_hz      <= rate;
      rate_item.snapped      <= snap;
      rate_item.rate_changed <= rate != last_rate;
    end
  end

endmodule

>>> dv/wordclock_rate_estimator_core_test.sv
// ----------------------------------------------------------------------------
// wordclock_rate_estimator_core_test
// Self-checking bench for the word-clock rate estimator. Scan items go in
// through the valid/stall channel. A local predictor divides, snaps to the
// standard audio rates within 1 percent and tracks the last reported rate.
// Each result is then compared field by field, in order, with the predicted
// one. Directed items cover the count extremes, every standard rate and the
// 1 percent edges. Random phases follow with varying sender idle and
// receiver stall.
// ----------------------------------------------------------------------------
module wordclock_rate_estimator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wcre_pkg::*;

  localparam longint unsigned WC_REF_HZ   = 64'd1280000000;
  localparam int unsigned     CYCLE_LIMIT = 1000000;
  localparam int unsigned     TAIL_CYCLES = 60;
  localparam int unsigned     AUDIO_RATES [13] = '{
    22050, 32000, 44100, 48000, 64000, 88200, 96000,
    128000, 176400, 192000, 256000, 352800, 384000
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   scan_valid = 1'b0;
  logic   scan_stall;
  scan_t  scan_item = '0;
  logic   rate_valid;
  logic   rate_stall = 1'b0;
  rate_t  rate_item;

  rate_t             expected_rates [$];
  logic [RATE_W-1:0] held_rate = '0;
  int unsigned       gap_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       cycles = 0;
  int unsigned       errors = 0;
  int unsigned       n_items = 0;
  int unsigned       n_results = 0;
  int unsigned       n_snapped = 0;
  int unsigned       n_not_ready = 0;
  int unsigned       n_changed = 0;
  scan_t             last_scan = '0;

  wordclock_rate_estimator_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .scan_valid (scan_valid),
    .scan_stall (scan_stall),
    .scan_item  (scan_item),
    .rate_valid (rate_valid),
    .rate_stall (rate_stall),
    .rate_item  (rate_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_rates.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    rate_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  function automatic rate_t predict_rate(input scan_t s, input logic [RATE_W-1:0] prev);
    logic [63:0] raw;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] target;
    logic        found;
    rate_t       r;
    r     = '0;
    found = 1'b0;
    if (s.scan_ready) begin
      raw       = WC_REF_HZ / ({46'd0, s.period_count} + 64'd1);
      lo        = raw * 64'd99;
      hi        = raw * 64'd101;
      r.rate_hz = raw[RATE_W-1:0];
      for (int i = 0; i < NUM_STD; i++) begin
        target = 64'(AUDIO_RATES[i]) * 64'd100;
        if (!found && target >= lo && target <= hi) begin
          found     = 1'b1;
          r.rate_hz = RATE_W'(AUDIO_RATES[i]);
          r.snapped = 1'b1;
        end
      end
    end
    r.rate_changed = (r.rate_hz != prev);
    return r;
  endfunction

  function automatic scan_t make_scan(input logic ready, input int unsigned count);
    scan_t s;
    s.scan_ready   = ready;
    s.period_count = COUNT_W'(count);
    return s;
  endfunction

  function automatic int unsigned count_for_rate(input int unsigned hz);
    return int'(WC_REF_HZ / 64'(hz)) - 1;
  endfunction

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    rate_t want;
    if (!rst && rate_valid && !rate_stall) begin
      n_results++;
      if (expected_rates.size() == 0) begin
        report_mismatch("result with no pending item", 0, rate_item.rate_hz);
      end else begin
        want = expected_rates.pop_front();
        if (rate_item.rate_hz !== want.rate_hz)
          report_mismatch("rate_hz", want.rate_hz, rate_item.rate_hz);
        if (rate_item.snapped !== want.snapped)
          report_mismatch("snapped", want.snapped, rate_item.snapped);
        if (rate_item.rate_changed !== want.rate_changed)
          report_mismatch("rate_changed", want.rate_changed, rate_item.rate_changed);
      end
    end
  end

  task automatic send_scan(input scan_t s);
    rate_t r;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      scan_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    scan_valid <= 1'b1;
    scan_item  <= s;
    do @(posedge clk); while (scan_stall);
    r = predict_rate(s, held_rate);
    held_rate = r.rate_hz;
    expected_rates.push_back(r);
    n_items++;
    if (!s.scan_ready) n_not_ready++;
    if (r.snapped) n_snapped++;
    if (r.rate_changed) n_changed++;
    last_scan = s;
  endtask

  task automatic wait_drained();
    scan_valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
  endtask

  task automatic test_ready_and_extremes();
    send_scan(make_scan(1'b0, 0));
    send_scan(make_scan(1'b1, 0));
    send_scan(make_scan(1'b1, 0));
    send_scan(make_scan(1'b0, 18'h3FFFF));
    send_scan(make_scan(1'b0, 18'h15555));
    send_scan(make_scan(1'b1, 18'h3FFFF));
    send_scan(make_scan(1'b1, 18'h2AAAA));
  endtask

  task automatic test_standard_rates();
    for (int i = 0; i < NUM_STD; i++)
      send_scan(make_scan(1'b1, count_for_rate(AUDIO_RATES[i])));
  endtask

  // 48 kHz: both edges of the 1 percent window, inside and just outside
  task automatic test_snap_window_edges();
    send_scan(make_scan(1'b1, 26398));
    send_scan(make_scan(1'b1, 26399));
    send_scan(make_scan(1'b1, 26932));
    send_scan(make_scan(1'b1, 26933));
  endtask

  function automatic scan_t random_scan();
    int unsigned pick;
    int unsigned base;
    int unsigned span;
    pick = $urandom_range(99);
    if (pick < 10)
      return make_scan(1'b0, $urandom_range(18'h3FFFF));
    if (pick < 25)
      return last_scan;
    if (pick < 70) begin
      base = count_for_rate(AUDIO_RATES[$urandom_range(NUM_STD - 1)]);
      span = base / 50 + 1;
      return make_scan(1'b1, base - span + $urandom_range(2 * span));
    end
    if (pick < 80)
      return make_scan(1'b1, $urandom_range(3400));
    return make_scan(1'b1, $urandom_range(18'h3FFFF));
  endfunction

  task automatic test_random_scans(input int unsigned gap_in, input int unsigned stall_in,
                                   input int unsigned count, input bit hold_midway);
    gap_pct   = gap_in;
    stall_pct = stall_in;
    for (int unsigned n = 0; n < count; n++) begin
      if (hold_midway && n == count / 2) wait_drained();
      send_scan(random_scan());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ready_and_extremes();
    test_standard_rates();
    test_snap_window_edges();

    test_random_scans(0, 0, 125, 1'b0);
    test_random_scans(77, 0, 125, 1'b0);
    test_random_scans(0, 77, 125, 1'b1);
    test_random_scans(35, 35, 125, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d scans (%0d not ready), checked %0d results in %0d cycles",
             n_items, n_not_ready, n_results, cycles);
    $display("%0d results snapped to a standard rate, %0d flagged a rate change",
             n_snapped, n_changed);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
